@@ src/segment_box_overlap_test_macros.svh @@
// Assertion macros shared by the segment box overlap test modules.
`ifndef SEGMENT_BOX_OVERLAP_TEST_MACROS_SVH
`define SEGMENT_BOX_OVERLAP_TEST_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define SBOT_ASSERT_NOW(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define SBOT_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error(msg);

`endif

@@ src/sbot_pkg.sv @@
// Package with widths and stage payload types of the segment box overlap test.
`default_nettype none

package sbot_pkg;

   localparam int COORD_WIDTH = 32;
   // Differences and extents gain one bit, the doubled center two.
   localparam int DLT_WIDTH = COORD_WIDTH + 1;
   localparam int CEN_WIDTH = COORD_WIDTH + 2;
   localparam int FCE_WIDTH = CEN_WIDTH + 1;
   localparam int PRD_WIDTH = DLT_WIDTH + CEN_WIDTH;
   localparam int SUM_WIDTH = PRD_WIDTH + 1;
   localparam int CMP_WIDTH = SUM_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DLT_WIDTH-1:0]   dlt_type;
   typedef logic        [DLT_WIDTH-1:0]   mag_type;
   typedef logic signed [CEN_WIDTH-1:0]   cen_type;
   typedef logic        [CEN_WIDTH-1:0]   cmag_type;
   typedef logic signed [FCE_WIDTH-1:0]   fce_type;
   typedef logic signed [PRD_WIDTH-1:0]   prd_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic signed [CMP_WIDTH-1:0]   cmp_type;

   typedef struct packed {
      coord_type [2:0] start_p;
      coord_type [2:0] end_p;
      coord_type [2:0] box_min;
      coord_type [2:0] box_max;
   } query_type;

   typedef struct packed {
      dlt_type [2:0] d;
      mag_type [2:0] dabs;
      cen_type [2:0] c;
      dlt_type [2:0] e;
   } prep_type;

   typedef struct packed {
      logic          face_sep;
      prd_type [2:0] pa;
      prd_type [2:0] pb;
      prd_type [2:0] qa;
      prd_type [2:0] qb;
   } prod_type;

   typedef struct packed {
      logic          face_sep;
      sum_type [2:0] lhs;
      sum_type [2:0] rhs;
   } comb_type;

endpackage

`default_nettype wire

@@ src/segment_box_overlap_test.sv @@
// Top level of the segment versus axis-aligned box overlap test.
`default_nettype none

// Tests a segment (start and end points) against an axis-aligned box (min and max
// corners), all signed Q16.16, on the three face axes and the three cross axes of
// the separating-axis test, exactly and without saturation. Each request gives one
// rsp_hit. The block is a four-stage pipeline (differences, products and face tests,
// cross sums, compares into the result register): it takes one request per cycle unless
// req_stall is high; each request passes the prep, product, sum and result registers.
// Each stage holds its request only while the stage after it is full and blocked, so empty
// stages still take new requests while a result waits on rsp_stall.
module segment_box_overlap_test
   import sbot_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire coord_type req_start_x,
   input  wire coord_type req_start_y,
   input  wire coord_type req_start_z,
   input  wire coord_type req_end_x,
   input  wire coord_type req_end_y,
   input  wire coord_type req_end_z,
   input  wire coord_type req_box_min_x,
   input  wire coord_type req_box_min_y,
   input  wire coord_type req_box_min_z,
   input  wire coord_type req_box_max_x,
   input  wire coord_type req_box_max_y,
   input  wire coord_type req_box_max_z,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output logic           rsp_hit
);

   query_type query;
   logic      prep_ready;
   logic      prep_valid;
   prep_type  prep_data;
   logic      mul_ready;
   logic      mul_valid;
   prod_type  mul_data;
   logic      cmp_ready;

   always_comb begin
      query.start_p = {req_start_z, req_start_y, req_start_x};
      query.end_p   = {req_end_z, req_end_y, req_end_x};
      query.box_min = {req_box_min_z, req_box_min_y, req_box_min_x};
      query.box_max = {req_box_max_z, req_box_max_y, req_box_max_x};
   end

   assign req_stall = !prep_ready;

   sbot_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (prep_ready),
      .up_data  (query),
      .dn_valid (prep_valid),
      .dn_ready (mul_ready),
      .dn_data  (prep_data)
   );

   sbot_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .up_valid (prep_valid),
      .up_ready (mul_ready),
      .up_data  (prep_data),
      .dn_valid (mul_valid),
      .dn_ready (cmp_ready),
      .dn_data  (mul_data)
   );

   sbot_cmp u_cmp (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (mul_valid),
      .up_ready  (cmp_ready),
      .up_data   (mul_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_hit   (rsp_hit)
   );

endmodule

`default_nettype wire

@@ src/sbot_prep.sv @@
// First pipeline stage: segment direction, doubled center offset and doubled extent.
`default_nettype none
`include "segment_box_overlap_test_macros.svh"

module sbot_prep
   import sbot_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      up_valid,
   output logic           up_ready,
   input  wire query_type up_data,
   output logic           dn_valid,
   input  wire logic      dn_ready,
   output prep_type       dn_data
);

   logic     vld_ff;
   prep_type dat_ff;
   prep_type dat_in;

   assign up_ready = !vld_ff || dn_ready;
   assign dn_valid = vld_ff;
   assign dn_data  = dat_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dat_in.d[i] = dlt_type'(up_data.end_p[i]) - dlt_type'(up_data.start_p[i]);
         dat_in.c[i] = cen_type'(up_data.start_p[i]) + cen_type'(up_data.end_p[i])
                     - cen_type'(up_data.box_min[i]) - cen_type'(up_data.box_max[i]);
         dat_in.e[i] = dlt_type'(up_data.box_max[i]) - dlt_type'(up_data.box_min[i]);
         // The most negative difference wraps to its correct unsigned magnitude.
         dat_in.dabs[i] = dat_in.d[i][DLT_WIDTH-1] ? mag_type'(-dat_in.d[i])
                                                   : mag_type'(dat_in.d[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         dat_ff <= dat_in;
      end
   end

   `SBOT_ASSERT_NEXT(a_prep_hold, clock, reset, vld_ff && !dn_ready, vld_ff && $stable(dat_ff),
                     "prep stage dropped or changed a stalled request")
   `SBOT_ASSERT_NOW(a_prep_dabs, clock, reset, !vld_ff || (dat_ff.dabs[0] != '0) ||
                    (dat_ff.d[0] == '0), "prep stage magnitude does not match difference")

endmodule

`default_nettype wire

@@ src/sbot_mul.sv @@
// Second pipeline stage: face axis tests and the products of the cross axis tests.
`default_nettype none

module sbot_mul
   import sbot_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     up_valid,
   output logic          up_ready,
   input  wire prep_type up_data,
   output logic          dn_valid,
   input  wire logic     dn_ready,
   output prod_type      dn_data
);

   logic     vld_ff;
   prod_type dat_ff;
   prod_type dat_in;
   cmag_type cabs [3];
   logic     fsep [3];

   assign up_ready = !vld_ff || dn_ready;
   assign dn_valid = vld_ff;
   assign dn_data  = dat_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cabs[i] = up_data.c[i][CEN_WIDTH-1] ? cmag_type'(-up_data.c[i])
                                             : cmag_type'(up_data.c[i]);
         fsep[i] = fce_type'(cabs[i]) >
                   (fce_type'(up_data.e[i]) + fce_type'(up_data.dabs[i]));
      end
      dat_in.face_sep = fsep[0] || fsep[1] || fsep[2];

      // Cross axis i uses the other two axes j = i + 1 and k = i + 2, modulo three.
      dat_in.pa[0] = prd_type'(up_data.d[1]) * prd_type'(up_data.c[2]);
      dat_in.pb[0] = prd_type'(up_data.d[2]) * prd_type'(up_data.c[1]);
      dat_in.qa[0] = prd_type'(up_data.e[1]) * prd_type'(up_data.dabs[2]);
      dat_in.qb[0] = prd_type'(up_data.e[2]) * prd_type'(up_data.dabs[1]);

      dat_in.pa[1] = prd_type'(up_data.d[2]) * prd_type'(up_data.c[0]);
      dat_in.pb[1] = prd_type'(up_data.d[0]) * prd_type'(up_data.c[2]);
      dat_in.qa[1] = prd_type'(up_data.e[2]) * prd_type'(up_data.dabs[0]);
      dat_in.qb[1] = prd_type'(up_data.e[0]) * prd_type'(up_data.dabs[2]);

      dat_in.pa[2] = prd_type'(up_data.d[0]) * prd_type'(up_data.c[1]);
      dat_in.pb[2] = prd_type'(up_data.d[1]) * prd_type'(up_data.c[0]);
      dat_in.qa[2] = prd_type'(up_data.e[0]) * prd_type'(up_data.dabs[1]);
      dat_in.qb[2] = prd_type'(up_data.e[1]) * prd_type'(up_data.dabs[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         dat_ff <= dat_in;
      end
   end

endmodule

`default_nettype wire

@@ src/sbot_cmp.sv @@
// Third and fourth pipeline stages: cross axis sums, final compares and the result register.
`default_nettype none
`include "segment_box_overlap_test_macros.svh"

module sbot_cmp
   import sbot_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     up_valid,
   output logic          up_ready,
   input  wire prod_type up_data,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output logic          rsp_hit
);

   logic     s3_vld_ff;
   comb_type s3_ff;
   comb_type s3_in;
   logic     s4_ready;
   logic     rsp_valid_ff;
   logic     rsp_hit_ff;
   logic     rsp_hit_in;
   logic     xsep [3];

   assign s4_ready  = !rsp_valid_ff || !rsp_stall;
   assign up_ready  = !s3_vld_ff || s4_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   always_comb begin
      s3_in.face_sep = up_data.face_sep;
      for (int i = 0; i < 3; i++) begin
         s3_in.lhs[i] = sum_type'(up_data.pa[i]) - sum_type'(up_data.pb[i]);
         s3_in.rhs[i] = sum_type'(up_data.qa[i]) + sum_type'(up_data.qb[i]);
      end
   end

   // |lhs| > rhs splits into lhs - rhs > 0 or lhs + rhs < 0, two adds side by side.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xsep[i] = ((cmp_type'(s3_ff.lhs[i]) - cmp_type'(s3_ff.rhs[i])) > cmp_type'(0)) ||
                   ((cmp_type'(s3_ff.lhs[i]) + cmp_type'(s3_ff.rhs[i])) < cmp_type'(0));
      end
      rsp_hit_in = !(s3_ff.face_sep || xsep[0] || xsep[1] || xsep[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (up_ready) begin
            s3_vld_ff <= up_valid;
         end
         if (s4_ready) begin
            rsp_valid_ff <= s3_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         s3_ff <= s3_in;
      end
      if (s4_ready) begin
         rsp_hit_ff <= rsp_hit_in;
      end
   end

   `SBOT_ASSERT_NEXT(a_cmp_hold, clock, reset, s3_vld_ff && !s4_ready,
                     s3_vld_ff && $stable(s3_ff), "sum stage lost a blocked request")
   `SBOT_ASSERT_NEXT(a_cmp_face, clock, reset, s3_vld_ff && s3_ff.face_sep && s4_ready,
                     rsp_valid_ff && !rsp_hit_ff, "face separation did not clear the hit")
   `SBOT_ASSERT_NEXT(a_cmp_load, clock, reset, s3_vld_ff && s4_ready, rsp_valid_ff,
                     "result register did not take a finished request")

endmodule

`default_nettype wire
